// ===== sv/rci_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rci_pkg: shared types and constants of the RC command interpolator
// Field widths, frame timing limits, divider sizing and sequencer states.
// ----------------------------------------------------------------------------
package rci_pkg;

   // field widths
   localparam int CMD_W   = 12;
   localparam int DELTA_W = 16;
   localparam int STEP_W  = 8;
   localparam int IV_W    = 16;
   localparam int LT_W    = 16;

   // channels
   localparam int NUM_CMD   = 4;
   localparam int CHANNELS  = 4;
   localparam int SMOOTH_CH = (CHANNELS < NUM_CMD) ? CHANNELS : NUM_CMD;
   localparam int CH_W      = (SMOOTH_CH > 1) ? $clog2(SMOOTH_CH) : 1;

   // frame timing
   localparam logic [IV_W-1:0] RX_MIN_US       = 16'd1000;
   localparam logic [IV_W-1:0] RX_MAX_US       = 16'd20000;
   localparam logic [IV_W-1:0] RX_MARGIN_US    = 16'd1000;
   localparam logic [LT_W-1:0] LOOP_TIME_MIN   = 16'd100;
   localparam logic [LT_W-1:0] LOOP_TIME_RESET = 16'd1000;

   // shared divider
   localparam int DIV_DVD_W = 24;
   localparam int DIV_DVS_W = 16;
   localparam int DIV_REM_W = DIV_DVS_W + 1;
   localparam int DIV_STEPS = DIV_DVD_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   // delta times step counter
   localparam int PROD_W = DIV_DVD_W + 1;

   typedef logic signed [CMD_W-1:0]   cmd_type;
   typedef logic signed [DELTA_W-1:0] delta_type;

   typedef struct packed {
      logic busy;
      logic done;
   } rci_div_sts_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_COUNT,
      ST_MUL,
      ST_ABS,
      ST_DIV,
      ST_UPD,
      ST_DONE
   } rci_state_type;

   typedef enum logic {
      PH_DELTA,
      PH_OUTPUT
   } rci_phase_type;

endpackage

// ===== sv/rci_divider.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rci_divider: iterative unsigned divider
// Restoring radix-2 division, one quotient bit per cycle. Quotient holds
// after done until the next start.
// ----------------------------------------------------------------------------
module rci_divider (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [rci_pkg::DIV_DVD_W-1:0]    dividend,
   input  logic [rci_pkg::DIV_DVS_W-1:0]    divisor,
   output rci_pkg::rci_div_sts_type         sts,
   output logic [rci_pkg::DIV_DVD_W-1:0]    quotient
);
   import rci_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_REM_W-1:0] rem_ff, rem_in;
   logic [DIV_DVD_W-1:0] quo_ff, quo_in;
   logic [DIV_DVS_W-1:0] dvs_ff, dvs_in;

   logic [DIV_REM_W-1:0] rem_sh;
   logic [DIV_REM_W:0]   diff;

   // one shift-subtract step
   always_comb begin
      rem_sh = {rem_ff[DIV_REM_W-2:0], quo_ff[DIV_DVD_W-1]};
      diff   = {1'b0, rem_sh} - {2'b00, dvs_ff};
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         if (!diff[DIV_REM_W]) begin
            rem_in = diff[DIV_REM_W-1:0];
            quo_in = {quo_ff[DIV_DVD_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh;
            quo_in = {quo_ff[DIV_DVD_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign sts.busy = busy_ff;
   assign sts.done = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== sv/rc_command_interpolator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc_command_interpolator: RC command smoothing between radio frames
// Sequencer around one multiplier and one shared iterative divider.
// ----------------------------------------------------------------------------
// One transfer in gives one transfer out. A tick that passes the commands
// through skips the divider. An interpolated ordinary tick divides once per
// channel; a new-frame tick divides for the step count, then per channel for
// the deltas and, when interpolation follows, per channel for the outputs.
// The shared divider retires one quotient bit per cycle over 24 bits and
// serves the step count and every channel in turn. The block stalls its
// input while an item is in work; a finished result waits in the output
// register, and the next item is taken as soon as its result is handed over.
// ----------------------------------------------------------------------------
module rc_command_interpolator (
   input  logic                          clock,
   input  logic                          reset,
   // input channel
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_mode,
   input  logic [rci_pkg::IV_W-1:0]      req_rx_interval_us,
   input  rci_pkg::cmd_type              req_cmd_roll_in,
   input  rci_pkg::cmd_type              req_cmd_pitch_in,
   input  rci_pkg::cmd_type              req_cmd_yaw_in,
   input  rci_pkg::cmd_type              req_cmd_throttle_in,
   // result channel
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output rci_pkg::cmd_type              rsp_cmd_roll_out,
   output rci_pkg::cmd_type              rsp_cmd_pitch_out,
   output rci_pkg::cmd_type              rsp_cmd_yaw_out,
   output rci_pkg::cmd_type              rsp_cmd_throttle_out,
   output logic                          rsp_interpolating,
   // loop time register
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [rci_pkg::LT_W-1:0]      csr_loop_time_us
);
   import rci_pkg::*;

   // state
   rci_state_type   state_ff, state_in;
   rci_phase_type   phase_ff, phase_in;
   logic [CH_W-1:0] ch_ff, ch_in;
   logic [LT_W-1:0] loop_time_ff, loop_time_in;

   cmd_type         last_ff  [SMOOTH_CH];
   cmd_type         last_in  [SMOOTH_CH];
   delta_type       delta_ff [SMOOTH_CH];
   delta_type       delta_in [SMOOTH_CH];
   cmd_type         cmd_ff   [SMOOTH_CH];
   cmd_type         cmd_in   [SMOOTH_CH];
   cmd_type         res_ff   [NUM_CMD];
   cmd_type         res_in   [NUM_CMD];
   logic [STEP_W-1:0] steps_left_ff, steps_left_in;
   logic [STEP_W-1:0] step_count_ff, step_count_in;

   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic                     neg_ff, neg_in;

   logic    rsp_valid_ff, rsp_valid_in;
   cmd_type rsp_cmd_ff [NUM_CMD];
   cmd_type rsp_cmd_in [NUM_CMD];
   logic    rsp_interp_ff, rsp_interp_in;

   // control
   logic accept;
   logic rsp_free;
   logic div_start;
   logic load_rsp;
   logic [DIV_DVD_W-1:0] div_dividend;
   logic [DIV_DVS_W-1:0] div_divisor;
   rci_div_sts_type      div_sts;
   logic [DIV_DVD_W-1:0] div_quo;

   // datapath helpers
   cmd_type              req_cmd [NUM_CMD];
   logic [IV_W-1:0]      iv_clamped;
   logic [IV_W-1:0]      iv_sum;
   logic [LT_W-1:0]      lt_eff;
   logic [STEP_W-1:0]    sl_dec;
   logic [STEP_W-1:0]    sl_frame;
   logic                 last_ch;
   cmd_type              last_sel;
   delta_type            delta_sel;
   cmd_type              cmd_sel;
   logic signed [PROD_W-1:0] prod_neg;
   logic [DIV_DVD_W-1:0] prod_mag;
   logic [DELTA_W-1:0]   q16;
   logic [DELTA_W-1:0]   scaled16;
   logic [DELTA_W-1:0]   last16;
   logic [DELTA_W-1:0]   cmd16;
   logic [DELTA_W-1:0]   smooth16;

   assign req_cmd[0] = req_cmd_roll_in;
   assign req_cmd[1] = req_cmd_pitch_in;
   assign req_cmd[2] = req_cmd_yaw_in;
   assign req_cmd[3] = req_cmd_throttle_in;

   assign accept   = req_valid && !req_stall;
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   // frame interval clamp, margin and loop time floor
   always_comb begin
      if (req_rx_interval_us < RX_MIN_US) begin
         iv_clamped = RX_MIN_US;
      end else if (req_rx_interval_us > RX_MAX_US) begin
         iv_clamped = RX_MAX_US;
      end else begin
         iv_clamped = req_rx_interval_us;
      end
      iv_sum = iv_clamped + RX_MARGIN_US;
      lt_eff = (loop_time_ff < LOOP_TIME_MIN) ? LOOP_TIME_MIN : loop_time_ff;
   end

   // step counter updates
   assign sl_dec   = (steps_left_ff != '0) ? steps_left_ff - 1'b1 : '0;
   assign sl_frame = step_count_ff - 1'b1;
   assign last_ch  = (ch_ff == CH_W'(SMOOTH_CH - 1));

   // per-channel operand select
   always_comb begin
      last_sel  = last_ff[ch_ff];
      delta_sel = delta_ff[ch_ff];
      cmd_sel   = cmd_ff[ch_ff];
   end

   // product magnitude for the divider
   always_comb begin
      prod_neg = -prod_ff;
      prod_mag = prod_ff[PROD_W-1] ? prod_neg[DIV_DVD_W-1:0] : prod_ff[DIV_DVD_W-1:0];
   end

   // signed quotient and smoothed value, modulo 16 bits
   always_comb begin
      q16      = div_quo[DELTA_W-1:0];
      scaled16 = neg_ff ? (16'd0 - q16) : q16;
      last16   = {{(DELTA_W-CMD_W){last_sel[CMD_W-1]}}, last_sel};
      cmd16    = {{(DELTA_W-CMD_W){cmd_sel[CMD_W-1]}}, cmd_sel};
      smooth16 = last16 - scaled16;
   end

   // sequencer: next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_mode) begin
                  state_in = ST_COUNT;
               end else if (sl_dec != '0) begin
                  state_in = ST_MUL;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_COUNT: begin
            if (div_sts.done) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            state_in = ST_ABS;
         end
         ST_ABS: begin
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (div_sts.done) begin
               state_in = ST_UPD;
            end
         end
         ST_UPD: begin
            if (!last_ch) begin
               state_in = ST_MUL;
            end else if (phase_ff == PH_DELTA && sl_frame != '0) begin
               state_in = ST_MUL;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // sequencer: control outputs
   always_comb begin
      req_stall    = 1'b1;
      div_start    = 1'b0;
      load_rsp     = 1'b0;
      div_dividend = DIV_DVD_W'(iv_sum);
      div_divisor  = lt_eff;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            div_start = req_valid && req_mode;
         end
         ST_ABS: begin
            div_start    = 1'b1;
            div_dividend = prod_mag;
            div_divisor  = DIV_DVS_W'(step_count_ff);
         end
         ST_DONE: begin
            load_rsp = rsp_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   // datapath registers: next values
   always_comb begin
      phase_in      = phase_ff;
      ch_in         = ch_ff;
      loop_time_in  = loop_time_ff;
      last_in       = last_ff;
      delta_in      = delta_ff;
      cmd_in        = cmd_ff;
      res_in        = res_ff;
      steps_left_in = steps_left_ff;
      step_count_in = step_count_ff;
      prod_in       = prod_ff;
      neg_in        = neg_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_cmd_in    = rsp_cmd_ff;
      rsp_interp_in = rsp_interp_ff;

      if (csr_valid && csr_ready) begin
         loop_time_in = csr_loop_time_us;
      end

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               res_in = req_cmd;
               for (int i = 0; i < SMOOTH_CH; i++) begin
                  cmd_in[i] = req_cmd[i];
               end
               ch_in = '0;
               if (!req_mode) begin
                  steps_left_in = sl_dec;
                  phase_in      = PH_OUTPUT;
               end
            end
         end
         ST_COUNT: begin
            if (div_sts.done) begin
               step_count_in = div_quo[STEP_W-1:0] + 1'b1;
               phase_in      = PH_DELTA;
               ch_in         = '0;
            end
         end
         ST_MUL: begin
            prod_in = delta_sel * $signed({1'b0, steps_left_ff});
         end
         ST_ABS: begin
            neg_in = prod_ff[PROD_W-1];
         end
         ST_UPD: begin
            for (int i = 0; i < SMOOTH_CH; i++) begin
               if (ch_ff == CH_W'(i)) begin
                  if (phase_ff == PH_DELTA) begin
                     delta_in[i] = cmd16 - smooth16;
                     last_in[i]  = cmd_sel;
                  end else begin
                     res_in[i] = smooth16[CMD_W-1:0];
                  end
               end
            end
            if (!last_ch) begin
               ch_in = ch_ff + 1'b1;
            end else if (phase_ff == PH_DELTA) begin
               steps_left_in = sl_frame;
               phase_in      = PH_OUTPUT;
               ch_in         = '0;
            end
         end
         ST_DONE: begin
            if (load_rsp) begin
               rsp_valid_in  = 1'b1;
               rsp_cmd_in    = res_ff;
               rsp_interp_in = (steps_left_ff != '0);
            end
         end
         default: begin
            ch_in = ch_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         phase_ff      <= PH_DELTA;
         ch_ff         <= '0;
         loop_time_ff  <= LOOP_TIME_RESET;
         steps_left_ff <= '0;
         step_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
         for (int i = 0; i < SMOOTH_CH; i++) begin
            last_ff[i]  <= '0;
            delta_ff[i] <= '0;
         end
      end else begin
         state_ff      <= state_in;
         phase_ff      <= phase_in;
         ch_ff         <= ch_in;
         loop_time_ff  <= loop_time_in;
         steps_left_ff <= steps_left_in;
         step_count_ff <= step_count_in;
         rsp_valid_ff  <= rsp_valid_in;
         last_ff       <= last_in;
         delta_ff      <= delta_in;
      end
      cmd_ff        <= cmd_in;
      res_ff        <= res_in;
      prod_ff       <= prod_in;
      neg_ff        <= neg_in;
      rsp_cmd_ff    <= rsp_cmd_in;
      rsp_interp_ff <= rsp_interp_in;
   end

   // shared divider
   rci_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .sts      (div_sts),
      .quotient (div_quo)
   );

   // ports
   assign csr_ready            = 1'b1;
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_cmd_roll_out     = rsp_cmd_ff[0];
   assign rsp_cmd_pitch_out    = rsp_cmd_ff[1];
   assign rsp_cmd_yaw_out      = rsp_cmd_ff[2];
   assign rsp_cmd_throttle_out = rsp_cmd_ff[3];
   assign rsp_interpolating    = rsp_interp_ff;

`ifndef SYNTH
   // step count quotient fits 8 bits
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_COUNT && div_sts.done) |-> (div_quo[DIV_DVD_W-1:STEP_W] == '0))
      else $error("step count quotient exceeds 8 bits");

   // interpolated quotient fits 15 bits, below the delta magnitude
   a_out_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UPD && phase_ff == PH_OUTPUT) |-> (div_quo[DIV_DVD_W-1:DELTA_W-1] == '0))
      else $error("interpolation quotient out of range");

   // counter never reaches the step count between items
   a_steps_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (steps_left_ff == '0 || steps_left_ff < step_count_ff))
      else $error("steps left not below step count");

   // divider is only started when free
   a_div_start: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_sts.busy)
      else $error("divider started while busy");
`endif

endmodule

// ===== dv/tb_rc_command_interpolator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rc_command_interpolator: self-checking bench for the RC command smoother
// A short directed table opens the run. Random frame-and-tick bursts follow,
// under several loop time settings and idle patterns. Every result transfer is
// compared per field against a typed result or the interpolation predictor.
// ----------------------------------------------------------------------------
module tb_rc_command_interpolator;
   import rci_pkg::*;

   localparam int DIRECTED_ROWS   = 21;
   localparam int PHASES          = 7;
   localparam int ITEMS_PER_PHASE = 240;
   localparam int LONG_HOLD       = 600;
   localparam int FINAL_WAIT      = 400;
   localparam int QUIET_LIMIT     = 4000;

   typedef struct packed {
      logic            mode;
      logic [IV_W-1:0] iv;
      cmd_type         roll;
      cmd_type         pitch;
      cmd_type         yaw;
      cmd_type         thr;
   } rc_tick_type;

   typedef struct packed {
      cmd_type roll;
      cmd_type pitch;
      cmd_type yaw;
      cmd_type thr;
      logic    interp;
   } rc_out_type;

   typedef struct packed {
      rc_tick_type tick;
      logic        known;
      rc_out_type  want;
   } script_row_type;

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;
   always #6 clock = ~clock;

   // block ports
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic              req_mode = 1'b0;
   logic [IV_W-1:0]   req_rx_interval_us = '0;
   cmd_type           req_cmd_roll_in = '0;
   cmd_type           req_cmd_pitch_in = '0;
   cmd_type           req_cmd_yaw_in = '0;
   cmd_type           req_cmd_throttle_in = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   cmd_type           rsp_cmd_roll_out;
   cmd_type           rsp_cmd_pitch_out;
   cmd_type           rsp_cmd_yaw_out;
   cmd_type           rsp_cmd_throttle_out;
   logic              rsp_interpolating;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [LT_W-1:0]   csr_loop_time_us = '0;

   rc_command_interpolator uut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_mode             (req_mode),
      .req_rx_interval_us   (req_rx_interval_us),
      .req_cmd_roll_in      (req_cmd_roll_in),
      .req_cmd_pitch_in     (req_cmd_pitch_in),
      .req_cmd_yaw_in       (req_cmd_yaw_in),
      .req_cmd_throttle_in  (req_cmd_throttle_in),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_cmd_roll_out     (rsp_cmd_roll_out),
      .rsp_cmd_pitch_out    (rsp_cmd_pitch_out),
      .rsp_cmd_yaw_out      (rsp_cmd_yaw_out),
      .rsp_cmd_throttle_out (rsp_cmd_throttle_out),
      .rsp_interpolating    (rsp_interpolating),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_loop_time_us     (csr_loop_time_us)
   );

   // predictor state
   int frame_cmd [NUM_CMD];
   int frame_delta [NUM_CMD];
   int steps_to_go = 0;
   int steps_per_frame = 0;
   int loop_time_cfg = int'(LOOP_TIME_RESET);

   // scoreboard and run bookkeeping
   rc_out_type  smoothed_q [$];
   rc_tick_type offered = '0;
   logic        offered_known = 1'b0;
   rc_out_type  offered_want = '0;
   int fails = 0;
   int ticks_taken = 0;
   int frames_taken = 0;
   int interp_seen = 0;
   int loop_writes = 0;
   int quiet_cycles = 0;
   int sender_idle_pct = 0;
   int rsp_stall_pct = 0;
   int hold_requests = 0;
   int holds_granted = 0;
   int hold_left = 0;

   script_row_type script [DIRECTED_ROWS];

   // step count for a frame interval under the current loop time
   function automatic int steps_for(input int iv);
      int lt;
      lt = (loop_time_cfg < int'(LOOP_TIME_MIN)) ? int'(LOOP_TIME_MIN) : loop_time_cfg;
      if (iv < int'(RX_MIN_US)) iv = int'(RX_MIN_US);
      if (iv > int'(RX_MAX_US)) iv = int'(RX_MAX_US);
      return (iv + int'(RX_MARGIN_US)) / lt + 1;
   endfunction

   // advance the predictor by one tick and return the smoothed commands
   function automatic rc_out_type interpolate_tick(input rc_tick_type t);
      int cmd [NUM_CMD];
      int res [NUM_CMD];
      int cnt;
      int prev;
      int diff;
      rc_out_type r;
      cmd[0] = $signed(t.roll);
      cmd[1] = $signed(t.pitch);
      cmd[2] = $signed(t.yaw);
      cmd[3] = $signed(t.thr);
      res = cmd;
      if (t.mode) begin
         cnt = steps_for(int'(t.iv));
         // rebase each delta on the value the old ramp had reached
         for (int i = 0; i < SMOOTH_CH; i++) begin
            prev = frame_cmd[i] - (frame_delta[i] * steps_to_go) / cnt;
            diff = cmd[i] - prev;
            frame_delta[i] = $signed(diff[DELTA_W-1:0]);
            frame_cmd[i] = cmd[i];
         end
         steps_per_frame = cnt & 'hFF;
         steps_to_go = (cnt - 1) & 'hFF;
      end else if (steps_to_go > 0) begin
         steps_to_go--;
      end
      if (steps_to_go > 0 && steps_per_frame != 0) begin
         for (int i = 0; i < SMOOTH_CH; i++)
            res[i] = frame_cmd[i] - (frame_delta[i] * steps_to_go) / steps_per_frame;
      end
      r.roll   = res[0][CMD_W-1:0];
      r.pitch  = res[1][CMD_W-1:0];
      r.yaw    = res[2][CMD_W-1:0];
      r.thr    = res[3][CMD_W-1:0];
      r.interp = (steps_to_go > 0);
      return r;
   endfunction

   function automatic cmd_type rand_cmd();
      case ($urandom_range(0, 7))
         0:       return cmd_type'(-2048);
         1:       return cmd_type'(2047);
         default: return cmd_type'($urandom);
      endcase
   endfunction

   // frame intervals mostly in range, with clamp cases on both sides
   function automatic rc_tick_type random_tick(input logic mode);
      rc_tick_type t;
      int pick;
      pick = $urandom_range(0, 99);
      t.mode = mode;
      if (pick < 60)      t.iv = IV_W'($urandom_range(1000, 20000));
      else if (pick < 75) t.iv = IV_W'($urandom_range(0, 999));
      else if (pick < 90) t.iv = IV_W'($urandom_range(20001, 65535));
      else                t.iv = IV_W'($urandom);
      t.roll  = rand_cmd();
      t.pitch = rand_cmd();
      t.yaw   = rand_cmd();
      t.thr   = rand_cmd();
      return t;
   endfunction

   task automatic check_field(input string name, input logic [CMD_W-1:0] want,
                              input logic [CMD_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, $signed(want), $signed(got));
         fails++;
      end
   endtask

   // offer one tick, with a random gap first when the sender idles
   task automatic offer_tick(input rc_tick_type t, input logic known,
                             input rc_out_type want);
      int gap;
      if ($urandom_range(0, 99) < sender_idle_pct) begin
         gap = $urandom_range(1, 40);
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid           <= 1'b1;
      req_mode            <= t.mode;
      req_rx_interval_us  <= t.iv;
      req_cmd_roll_in     <= t.roll;
      req_cmd_pitch_in    <= t.pitch;
      req_cmd_yaw_in      <= t.yaw;
      req_cmd_throttle_in <= t.thr;
      offered             <= t;
      offered_known       <= known;
      offered_want        <= want;
      do @(posedge clock); while (req_stall);
   endtask

   // stop offering and let every expected result come back
   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (smoothed_q.size() != 0) @(negedge clock);
   endtask

   task automatic write_loop_time(input int value);
      @(negedge clock);
      csr_valid        <= 1'b1;
      csr_loop_time_us <= LT_W'(value);
      do @(posedge clock); while (!csr_ready);
      loop_time_cfg = value & 'hFFFF;
      loop_writes++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // receiver: random stalls, plus a long hold when one is requested
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else if (holds_granted != hold_requests) begin
         holds_granted++;
         hold_left = LONG_HOLD - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < rsp_stall_pct);
      end
   end

   // scoreboard: check results, predict accepted ticks, watch for a hang
   always @(posedge clock) begin : score
      rc_out_type want;
      rc_out_type pred;
      logic moved;
      moved = 1'b0;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            moved = 1'b1;
            if (smoothed_q.size() == 0) begin
               $error("result transfer with no expected result pending");
               fails++;
            end else begin
               want = smoothed_q.pop_front();
               check_field("cmd_roll_out", want.roll, rsp_cmd_roll_out);
               check_field("cmd_pitch_out", want.pitch, rsp_cmd_pitch_out);
               check_field("cmd_yaw_out", want.yaw, rsp_cmd_yaw_out);
               check_field("cmd_throttle_out", want.thr, rsp_cmd_throttle_out);
               check_field("interpolating", CMD_W'(want.interp),
                           CMD_W'(rsp_interpolating));
               if (rsp_interpolating === 1'b1) interp_seen++;
            end
         end
         if (req_valid && !req_stall) begin
            moved = 1'b1;
            pred = interpolate_tick(offered);
            smoothed_q.push_back(offered_known ? offered_want : pred);
            ticks_taken++;
            if (offered.mode) frames_taken++;
         end
         if (csr_valid && csr_ready) moved = 1'b1;
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
         $display("rc_command_interpolator: mismatch");
         $finish;
      end
   end

   // stimulus
   initial begin
      rc_tick_type t;
      int left;
      int n;
      int cnt;
      logic hold_issued;
      hold_issued = 1'b0;
      foreach (frame_cmd[i]) begin
         frame_cmd[i] = 0;
         frame_delta[i] = 0;
      end

      // directed table: tick, whether the result is typed in, typed result
      script = '{
         // pass-through right after reset, field extremes
         '{'{1'b0, 16'd0,     2047, -2048,     0,    -1}, 1'b1, '{2047, -2048, 0, -1, 1'b0}},
         '{'{1'b0, 16'd65535, -2048, 2047,    -1,     0}, 1'b1, '{-2048, 2047, -1, 0, 1'b0}},
         // short interval clamps up: three steps
         '{'{1'b1, 16'd0,     2047, -2048,  1000, -1000}, 1'b0, '0},
         '{'{1'b0, 16'd0,        0,     0,     0,     0}, 1'b0, '0},
         '{'{1'b0, 16'd12345,    5,    -5,   100,  -100}, 1'b1, '{5, -5, 100, -100, 1'b0}},
         // counter already at zero stays there
         '{'{1'b0, 16'hAAAA,    -1,     1, -2048,  2047}, 1'b1, '{-1, 1, -2048, 2047, 1'b0}},
         // long interval clamps down, then frames arrive mid-ramp
         '{'{1'b1, 16'd65535, -2048, 2047,    -1,     1}, 1'b0, '0},
         '{'{1'b0, 16'h5555,     7,     7,     7,     7}, 1'b0, '0},
         '{'{1'b1, 16'd999,   2047, -2048,  2047, -2048}, 1'b0, '0},
         '{'{1'b1, 16'd1000, -2048,  2047, -2048,  2047}, 1'b0, '0},
         '{'{1'b1, 16'd20000, 2047,  2047, -2048, -2048}, 1'b0, '0},
         '{'{1'b1, 16'd20001,    0,     0,     0,     0}, 1'b0, '0},
         // back-to-back short frames inflate the deltas until they wrap
         '{'{1'b1, 16'd0,    -2048, -2048,  2047,  2047}, 1'b0, '0},
         '{'{1'b1, 16'd0,     2047, -2048,  2047, -2048}, 1'b0, '0},
         '{'{1'b1, 16'd1,    -2048,  2047, -2048,  2047}, 1'b0, '0},
         '{'{1'b0, 16'd0,        0,     0,     0,     0}, 1'b0, '0},
         '{'{1'b0, 16'd65535,  100,   200,   300,   400}, 1'b1, '{100, 200, 300, 400, 1'b0}},
         '{'{1'b1, 16'd19999,    1,    -1,     2,    -2}, 1'b0, '0},
         '{'{1'b1, 16'd32768, -1000, 1000, -2000,  2000}, 1'b0, '0},
         '{'{1'b0, 16'd0,       11,   -11,    22,   -22}, 1'b0, '0},
         '{'{1'b0, 16'hFFFF,   -33,    33,   -44,    44}, 1'b0, '0}
      };

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (script[i])
         offer_tick(script[i].tick, script[i].known, script[i].want);

      for (int phase = 0; phase < PHASES; phase++) begin
         // settings change only with the block drained
         if (phase > 0) begin
            wait_drained();
            case (phase)
               1:       write_loop_time(100);
               2:       write_loop_time(65535);
               3:       write_loop_time(0);
               4:       write_loop_time(50);
               5:       write_loop_time($urandom_range(100, 5000));
               default: write_loop_time(2000);
            endcase
         end
         case (phase % 4)
            0:       begin sender_idle_pct = 0;  rsp_stall_pct = 0;  end
            1:       begin sender_idle_pct = 66; rsp_stall_pct = 0;  end
            2:       begin sender_idle_pct = 0;  rsp_stall_pct = 66; end
            default: begin sender_idle_pct = 26; rsp_stall_pct = 26; end
         endcase

         left = ITEMS_PER_PHASE;
         while (left > 0) begin
            // long receiver hold while the sender keeps offering
            if (phase == 0 && !hold_issued && left < ITEMS_PER_PHASE - 40) begin
               hold_requests++;
               hold_issued = 1'b1;
            end
            if ($urandom_range(0, 4) != 0) begin
               // a frame followed by a run of ordinary ticks
               t = random_tick(1'b1);
               cnt = steps_for(int'(t.iv));
               offer_tick(t, 1'b0, '0);
               left--;
               n = $urandom_range(0, cnt + 2);
               while (n > 0 && left > 0) begin
                  offer_tick(random_tick(1'b0), 1'b0, '0);
                  n--;
                  left--;
               end
            end else begin
               // noise: any mode, any content
               offer_tick(random_tick(1'($urandom_range(0, 1))), 1'b0, '0);
               left--;
            end
         end
      end

      wait_drained();
      repeat (FINAL_WAIT) @(posedge clock);
      if (smoothed_q.size() != 0) begin
         $error("%0d expected results never arrived", smoothed_q.size());
         fails++;
      end
      $display("run covered %0d ticks, %0d of them new frames, %0d interpolated results",
               ticks_taken, frames_taken, interp_seen);
      $display("loop time written %0d times, including 0, 50, 100 and 65535", loop_writes);
      if (fails == 0)
         $display("rc_command_interpolator: match");
      else
         $display("rc_command_interpolator: mismatch");
      $finish;
   end

endmodule

// ===== sim.f =====
sv/rci_pkg.sv
sv/rci_divider.sv
sv/rc_command_interpolator.sv
dv/tb_rc_command_interpolator.sv
